// ----- rtl/wsc_pkg.sv -----
// Shared types, constants and tables for the waypoint steering controller.
package wsc_pkg;

  localparam int unsigned RegW   = 25;
  localparam int unsigned CoordW = 31;
  localparam int unsigned HeadW  = 19;
  localparam int unsigned AngW   = 35;   // Q30 angles with headroom for wrap
  localparam int unsigned VecW   = 52;   // vectoring x/y datapath
  localparam int unsigned RotW   = 33;   // rotation x/y datapath

  localparam logic [1:0] CfgSlowRadius   = 2'd0;
  localparam logic [1:0] CfgMaxSpeed     = 2'd1;
  localparam logic [1:0] CfgTurningGain  = 2'd2;
  localparam logic [1:0] CfgVerticalGain = 2'd3;

  localparam logic signed [AngW-1:0] PiQ30     = 35'sd3373259426;
  localparam logic signed [AngW-1:0] TwoPiQ30  = 35'sd6746518852;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 35'sd1686629713;
  localparam logic signed [AngW-1:0] LimitQ30  = 35'sd1685774664;
  localparam logic signed [RotW-1:0] OneQ30    = 33'sd1073741824;
  localparam logic [29:0]            InvKQ30   = 30'd652032874;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [AngW-1:0] atan_q30(input int unsigned i);
    logic signed [AngW-1:0] r;
    begin
      r = '0;
      case (i)
        0: r = 35'sd843314856;
        1: r = 35'sd497837829;
        2: r = 35'sd263043836;
        3: r = 35'sd133525158;
        4: r = 35'sd67021686;
        5: r = 35'sd33543515;
        6: r = 35'sd16775850;
        7: r = 35'sd8388437;
        8: r = 35'sd4194282;
        9: r = 35'sd2097149;
        default: begin
          if (i < 30) r = (35'sd1 <<< (30 - i)) - 35'sd1;
          else r = '0;
        end
      endcase
      return r;
    end
  endfunction

  // Per-item data carried down the chain of cells.
  typedef struct packed {
    logic                     has_target;
    logic                     zero_vec;
    logic signed [VecW-1:0]   vx;
    logic signed [VecW-1:0]   vy;
    logic signed [AngW-1:0]   vz;
    logic signed [HeadW-1:0]  heading;
    logic signed [32:0]       dz;
  } vec_item_t;

  typedef struct packed {
    logic                     has_target;
    logic [31:0]              dist_val;  // planar distance, Q16.16
    logic signed [AngW-1:0]   err;
    logic                     neg;
    logic signed [RotW-1:0]   rx;
    logic signed [RotW-1:0]   ry;
    logic signed [AngW-1:0]   rt;
    logic signed [32:0]       dz;
  } rot_item_t;

endpackage

// ----- rtl/wsc_vec_cell.sv -----
// One vectoring CORDIC micro-rotation stage.
module wsc_vec_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  wsc_pkg::vec_item_t    d_i,
  output wsc_pkg::vec_item_t    d_o
);
  wsc_pkg::vec_item_t nxt;
  logic signed [wsc_pkg::VecW-1:0] xs, ys;

  always_comb begin
    nxt = d_i;
    xs  = d_i.vx >>> Idx;
    ys  = d_i.vy >>> Idx;
    if (d_i.vy >= 0) begin
      nxt.vx = d_i.vx + ys;
      nxt.vy = d_i.vy - xs;
      nxt.vz = d_i.vz + wsc_pkg::atan_q30(Idx);
    end else begin
      nxt.vx = d_i.vx - ys;
      nxt.vy = d_i.vy + xs;
      nxt.vz = d_i.vz - wsc_pkg::atan_q30(Idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) d_o <= nxt;
  end
endmodule

// ----- rtl/wsc_rot_cell.sv -----
// One rotating CORDIC micro-rotation stage.
module wsc_rot_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  wsc_pkg::rot_item_t    d_i,
  output wsc_pkg::rot_item_t    d_o
);
  wsc_pkg::rot_item_t nxt;
  logic signed [wsc_pkg::RotW-1:0] xs, ys;

  always_comb begin
    nxt = d_i;
    xs  = d_i.rx >>> Idx;
    ys  = d_i.ry >>> Idx;
    if (d_i.rt >= 0) begin
      nxt.rx = d_i.rx - ys;
      nxt.ry = d_i.ry + xs;
      nxt.rt = d_i.rt - wsc_pkg::atan_q30(Idx);
    end else begin
      nxt.rx = d_i.rx + ys;
      nxt.ry = d_i.ry - xs;
      nxt.rt = d_i.rt + wsc_pkg::atan_q30(Idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) d_o <= nxt;
  end
endmodule

// ----- rtl/wsc_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, carries a payload along.
module wsc_div #(
  parameter int unsigned NumW = 51,
  parameter int unsigned DenW = 25,
  parameter int unsigned PayW = 8
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NumW-1:0]   num_i,
  input  logic [DenW-1:0]   den_i,
  input  logic [PayW-1:0]   pay_i,
  output logic [NumW-1:0]   quo_o,
  output logic [PayW-1:0]   pay_o
);
  logic [NumW-1:0] num_q [NumW+1];
  logic [NumW-1:0] quo_q [NumW+1];
  logic [DenW:0]   rem_q [NumW+1];
  logic [DenW-1:0] den_q [NumW+1];
  logic [PayW-1:0] pay_q [NumW+1];

  always_comb begin
    num_q[0] = num_i;
    quo_q[0] = '0;
    rem_q[0] = '0;
    den_q[0] = den_i;
    pay_q[0] = pay_i;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW+1:0] trial, diff;
    logic            take;
    logic [NumW-1:0] quo_nxt;
    always_comb begin
      trial   = {rem_q[s], num_q[s][NumW-1-s]};
      diff    = trial - {2'b00, den_q[s]};
      take    = trial >= {2'b00, den_q[s]};
      quo_nxt = quo_q[s];
      quo_nxt[NumW-1-s] = take;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= num_q[s];
        den_q[s+1] <= den_q[s];
        pay_q[s+1] <= pay_q[s];
        quo_q[s+1] <= quo_nxt;
        rem_q[s+1] <= take ? diff[DenW:0] : trial[DenW:0];
      end
    end
  end

  assign quo_o = quo_q[NumW];
  assign pay_o = pay_q[NumW];
endmodule

// ----- rtl/waypoint_steering_controller.sv -----
// Throughput: one item per cycle; the whole chain of CORDIC cells, multipliers and the
// pipelined speed divider advances together whenever the output slot is empty or draining.
// Reset: rst_ni asynchronously clears all valid bits and returns the config registers to defaults.
// Configuration writes are accepted every cycle and must only occur when the block is idle.
module waypoint_steering_controller #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: goal_x, goal_y, goal_z, pos_x, pos_y, pos_z, heading (205 bits, padded to 208)
  input  logic [207:0] s_axis_tdata,
  // tuser: has_target
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: speed_cmd[24:0], turn_rate_cmd[50:25], climb_rate_cmd[82:51], zero pad to 88
  output logic [87:0]  m_axis_tdata,
  // tuser: updated
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [24:0]  cfg_data_i
);
  localparam int unsigned RW = wsc_pkg::RegW;
  localparam int unsigned NS = CORDIC_STAGES;
  // registers after acceptance, in order: front, vec cells, dist mul, wrap, rot cells, post,
  // divider stages, output
  localparam int unsigned DivW = 51;
  localparam int unsigned Lat  = 2 * NS + DivW + 4;

  logic [RW-1:0] slow_radius_q, max_speed_q, turning_gain_q, vertical_gain_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_radius_q   <= 25'd19661;
      max_speed_q     <= 25'd22938;
      turning_gain_q  <= 25'd2621440;
      vertical_gain_q <= 25'd655360;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        wsc_pkg::CfgSlowRadius:   slow_radius_q   <= cfg_data_i;
        wsc_pkg::CfgMaxSpeed:     max_speed_q     <= cfg_data_i;
        wsc_pkg::CfgTurningGain:  turning_gain_q  <= cfg_data_i;
        wsc_pkg::CfgVerticalGain: vertical_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advances when output slot is empty or being drained.
  logic out_vld_q;
  logic adv;
  logic [Lat-1:0] vld_q;
  assign adv = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
  end

  // Front stage: differences and pre-rotation.
  logic signed [30:0] gx, gy, gz, px, py, pz;
  logic signed [18:0] hd_in;
  assign gx = s_axis_tdata[30:0];
  assign gy = s_axis_tdata[61:31];
  assign gz = s_axis_tdata[92:62];
  assign px = s_axis_tdata[123:93];
  assign py = s_axis_tdata[154:124];
  assign pz = s_axis_tdata[185:155];
  assign hd_in = s_axis_tdata[204:186];

  wsc_pkg::vec_item_t front_d, vec_q [NS+1];
  logic signed [31:0] dxw, dyw;
  always_comb begin
    dxw = 32'(gx) - 32'(px);
    dyw = 32'(gy) - 32'(py);
    front_d.has_target = s_axis_tuser;
    front_d.zero_vec   = (dxw == 0) && (dyw == 0);
    front_d.heading    = hd_in;
    front_d.dz         = 33'(gz) - 33'(pz);
    front_d.vz         = '0;
    front_d.vx = wsc_pkg::VecW'(dxw) <<< 16;
    front_d.vy = wsc_pkg::VecW'(dyw) <<< 16;
    if (dxw < 0) begin
      front_d.vz = (dyw >= 0) ? wsc_pkg::PiQ30 : -wsc_pkg::PiQ30;
      front_d.vx = -front_d.vx;
      front_d.vy = -front_d.vy;
    end
  end
  always_ff @(posedge clk_i) if (adv) vec_q[0] <= front_d;

  for (genvar i = 0; i < NS; i++) begin : g_vec
    wsc_vec_cell #(.Idx(i)) u_cell (.clk_i, .en_i(adv), .d_i(vec_q[i]), .d_o(vec_q[i+1]));
  end

  // Distance: round off guard bits, multiply by 1/K, then wrap heading error.
  wsc_pkg::vec_item_t vm_q;
  logic [35:0] xr;
  logic [65:0] dprod_q;
  always_comb xr = 36'((vec_q[NS].vx + 52'sd32768) >>> 16);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vm_q    <= vec_q[NS];
      dprod_q <= 66'(xr) * 66'(wsc_pkg::InvKQ30) + (66'd1 << 29);
    end
  end

  wsc_pkg::rot_item_t rot_q [NS+1];
  wsc_pkg::rot_item_t wrap_d;
  logic signed [wsc_pkg::AngW-1:0] e0, e1, e2, e3, e4, zz;
  always_comb begin
    zz = vm_q.zero_vec ? '0 : vm_q.vz;
    e0 = zz - (wsc_pkg::AngW'(vm_q.heading) <<< (30 - FRAC_BITS));
    e1 = (e0 > wsc_pkg::PiQ30) ? e0 - wsc_pkg::TwoPiQ30 : e0;
    e2 = (e1 <= -wsc_pkg::PiQ30) ? e1 + wsc_pkg::TwoPiQ30 : e1;
    e3 = (e2 > wsc_pkg::PiQ30) ? e2 - wsc_pkg::TwoPiQ30 : e2;
    e4 = (e3 <= -wsc_pkg::PiQ30) ? e3 + wsc_pkg::TwoPiQ30 : e3;
    wrap_d.has_target = vm_q.has_target;
    wrap_d.dist_val = vm_q.zero_vec ? '0 : 32'(dprod_q[65:30]);
    wrap_d.err  = e4;
    wrap_d.dz   = vm_q.dz;
    wrap_d.rx   = wsc_pkg::RotW'(wsc_pkg::InvKQ30);
    wrap_d.ry   = '0;
    wrap_d.neg  = 1'b0;
    wrap_d.rt   = e4;
    if (e4 > wsc_pkg::HalfPiQ30) begin
      wrap_d.rt = e4 - wsc_pkg::PiQ30;  wrap_d.neg = 1'b1;
    end else if (e4 < -wsc_pkg::HalfPiQ30) begin
      wrap_d.rt = e4 + wsc_pkg::PiQ30;  wrap_d.neg = 1'b1;
    end
  end
  always_ff @(posedge clk_i) if (adv) rot_q[0] <= wrap_d;

  for (genvar i = 0; i < NS; i++) begin : g_rot
    wsc_rot_cell #(.Idx(i)) u_cell (.clk_i, .en_i(adv), .d_i(rot_q[i]), .d_o(rot_q[i+1]));
  end

  // Post stage: clamp, turn and climb products, speed numerator.
  logic signed [wsc_pkg::RotW-1:0] cx, sy, cs, sn;
  always_comb begin
    cx = rot_q[NS].neg ? -rot_q[NS].rx : rot_q[NS].rx;
    sy = rot_q[NS].neg ? -rot_q[NS].ry : rot_q[NS].ry;
    cs = (cx > wsc_pkg::OneQ30) ? wsc_pkg::OneQ30 : (cx < -wsc_pkg::OneQ30) ? -wsc_pkg::OneQ30 : cx;
    sn = (sy > wsc_pkg::OneQ30) ? wsc_pkg::OneQ30 : (sy < -wsc_pkg::OneQ30) ? -wsc_pkg::OneQ30 : sy;
  end

  localparam int unsigned PayW = 1 + 2 + 31 + 25 + 26 + 32;
  logic [DivW-1:0] num_d;
  logic            far_d, zr_d;
  logic [30:0]     cabs_d;
  logic signed [25:0] turn_d;
  logic signed [31:0] climb_d;
  logic signed [58:0] tprod;
  logic signed [58:0] cprod;
  logic [PayW-1:0] pay_d, pay_o;
  logic [DivW-1:0] quo_o;

  always_comb begin
    far_d  = rot_q[NS].dist_val > 32'(slow_radius_q);
    zr_d   = slow_radius_q == '0;
    cabs_d = 31'(cs < 0 ? -cs : cs);
    // only used when the distance is within the slow radius, so it fits RW bits
    num_d  = DivW'(max_speed_q) * DivW'(rot_q[NS].dist_val[RW-1:0]);
    tprod  = 59'(signed'({1'b0, turning_gain_q})) * 59'(sn);
    cprod  = 59'(signed'({1'b0, vertical_gain_q})) * 59'(rot_q[NS].dz);
    if (rot_q[NS].err > wsc_pkg::LimitQ30) turn_d = 26'(turning_gain_q);
    else if (rot_q[NS].err < -wsc_pkg::LimitQ30) turn_d = -26'(turning_gain_q);
    else turn_d = 26'(tprod >>> 30);
    cprod = cprod >>> FRAC_BITS;
    if (cprod > 59'sd2147483647) climb_d = 32'h7fffffff;
    else if (cprod < -59'sd2147483648) climb_d = 32'h80000000;
    else climb_d = 32'(cprod);
    pay_d = {rot_q[NS].has_target, far_d, zr_d, cabs_d, max_speed_q, turn_d, climb_d};
  end

  logic [DivW-1:0] num_q;
  logic [RW-1:0]   den_q;
  logic [PayW-1:0] pay_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= num_d;
      den_q <= zr_d ? 25'd1 : slow_radius_q;
      pay_q <= pay_d;
    end
  end

  wsc_div #(.NumW(DivW), .DenW(RW), .PayW(PayW)) u_div (
    .clk_i, .en_i(adv), .num_i(num_q), .den_i(den_q), .pay_i(pay_q),
    .quo_o, .pay_o
  );

  // Final stage: scale by |cos| and select.
  logic            p_ht, p_far, p_zr;
  logic [30:0]     p_cabs;
  logic [RW-1:0]   p_ms;
  logic [25:0]     p_turn;
  logic [31:0]     p_climb;
  logic [55:0]     sprod;
  logic [RW-1:0]   speed_d;
  assign {p_ht, p_far, p_zr, p_cabs, p_ms, p_turn, p_climb} = pay_o;
  always_comb begin
    // quotient never exceeds max_speed when it is used
    sprod = 56'(quo_o[RW-1:0]) * 56'(p_cabs);
    if (p_far) speed_d = p_ms;
    else if (p_zr) speed_d = '0;
    else speed_d = RW'(sprod >> 30);
  end

  logic [87:0] out_data_q;
  logic        out_user_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= vld_q[Lat-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_user_q <= p_ht;
      out_data_q <= p_ht ? {5'd0, p_climb, p_turn, speed_d} : '0;
    end
  end
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
endmodule

// ----- rtl/wsc_checker.sv -----
// Port-level checker for the waypoint steering controller, bound to the top level.
module wsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        cfg_ready_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output slot");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("item without target gave nonzero result");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port stalled");
endmodule

bind waypoint_steering_controller wsc_checker u_wsc_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser, .cfg_ready_o
);
